FILE: design/sorted_list_insert_delete_defines.svh
// Assertion macros for the sorted list block.
`ifndef SORTED_LIST_INSERT_DELETE_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_DEFINES_SVH
`ifndef ASSERT_OFF
`define SLI_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SLI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SLI_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define SLI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: design/sli_pkg.sv
`default_nettype none
package sli_pkg;

  localparam int DATA_W = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

endpackage
`default_nettype wire

FILE: design/sorted_list_insert_delete.sv
`default_nettype none
// Sorted list block: keeps up to DEPTH signed 32-bit values in ascending order.
// A transaction is accepted at a rising edge where start is high and busy is
// low; operation selects insert or delete and value carries the operand.
// An insert places the value in front of any equal entries, or is dropped with
// status full when the table holds DEPTH entries. A delete removes the first
// equal entry, or reports not found. Each transaction gives exactly one result:
// done is high for one cycle with status, entry_count and smallest_value, and
// the receiver takes it in that cycle; it cannot hold results off.
// The entries live in one memory with a registered read. An insert walks
// down from the top entry, moving one larger-or-equal entry up per cycle; a
// delete walks up to the match and then moves one entry down per cycle. An
// insert stays busy while it moves entries and ends with the compare that
// stops the walk or the write of slot 0; a delete stays busy while it scans
// for the match and closes the gap, or scans the whole table. done rises at the
// same edge where busy falls. Full inserts, deletes on an empty table and
// inserts into an empty table never raise busy. A new transaction may be
// accepted in the cycle done is high. Reset empties the table at once;
// the memory itself is never cleared because only live entries are read.
`include "sorted_list_insert_delete_defines.svh"
module sorted_list_insert_delete #(
  parameter int DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                operation,
  input  wire logic signed [sli_pkg::DATA_W-1:0]   value,
  output logic                                     done,
  output logic             [1:0]                   status,
  output logic             [$clog2(DEPTH+1)-1:0]   entry_count,
  output logic signed      [sli_pkg::DATA_W-1:0]   smallest_value
);
  import sli_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_EVAL,
    S_INS_LAST,
    S_DEL_EVAL,
    S_DEL_SHIFT
  } state_t;

  state_t            state, state_next;
  logic              op_q;
  logic [DATA_W-1:0] val_q;
  logic [CW-1:0]     count, count_next;
  logic [AW-1:0]     hole, hole_next;
  logic [AW-1:0]     idx, idx_next;
  logic [DATA_W-1:0] smallest;
  logic              done_next;
  status_t           status_q, status_next;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata, rdata;

  logic [CW-1:0]     cnt_m1;
  logic [AW-1:0]     last_idx;
  logic [AW-1:0]     idx_p1, idx_p2;

  assign cnt_m1   = count - CW'(1);
  assign last_idx = cnt_m1[AW-1:0];
  assign idx_p1   = idx + AW'(1);
  assign idx_p2   = idx + AW'(2);

  sli_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // The read address is issued combinationally so that the data of the entry
  // under test arrives in the next cycle, while the current entry is written.
  always_comb begin
    state_next  = state;
    count_next  = count;
    hole_next   = hole;
    idx_next    = idx;
    done_next   = 1'b0;
    status_next = status_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = val_q;
    raddr       = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (operation == OP_INSERT) begin
            if (count == CW'(DEPTH)) begin
              done_next   = 1'b1;
              status_next = ST_FULL;
            end else if (count == '0) begin
              we          = 1'b1;
              waddr       = '0;
              wdata       = value;
              count_next  = CW'(1);
              done_next   = 1'b1;
              status_next = ST_DONE;
            end else begin
              hole_next  = count[AW-1:0];
              raddr      = last_idx;
              state_next = S_INS_EVAL;
            end
          end else begin
            if (count == '0) begin
              done_next   = 1'b1;
              status_next = ST_NOT_FOUND;
            end else begin
              idx_next   = '0;
              raddr      = '0;
              state_next = S_DEL_EVAL;
            end
          end
        end
      end
      S_INS_EVAL: begin
        we = 1'b1;
        waddr = hole;
        if ($signed(rdata) >= $signed(val_q)) begin
          // Entry is not smaller than the new value: move it up one slot.
          wdata     = rdata;
          hole_next = hole - AW'(1);
          if (hole == AW'(1)) begin
            state_next = S_INS_LAST;
          end else begin
            raddr = hole - AW'(2);
          end
        end else begin
          wdata       = val_q;
          count_next  = count + CW'(1);
          done_next   = 1'b1;
          status_next = ST_DONE;
          state_next  = S_IDLE;
        end
      end
      S_INS_LAST: begin
        we          = 1'b1;
        waddr       = '0;
        wdata       = val_q;
        count_next  = count + CW'(1);
        done_next   = 1'b1;
        status_next = ST_DONE;
        state_next  = S_IDLE;
      end
      S_DEL_EVAL: begin
        if (rdata == val_q) begin
          if (idx == last_idx) begin
            count_next  = cnt_m1;
            done_next   = 1'b1;
            status_next = ST_DONE;
            state_next  = S_IDLE;
          end else begin
            raddr      = idx_p1;
            state_next = S_DEL_SHIFT;
          end
        end else if (idx == last_idx) begin
          done_next   = 1'b1;
          status_next = ST_NOT_FOUND;
          state_next  = S_IDLE;
        end else begin
          idx_next = idx_p1;
          raddr    = idx_p1;
        end
      end
      S_DEL_SHIFT: begin
        // Close the gap: the entry above moves down into the current slot.
        we       = 1'b1;
        waddr    = idx;
        wdata    = rdata;
        idx_next = idx_p1;
        if (idx_p1 == last_idx) begin
          count_next  = cnt_m1;
          done_next   = 1'b1;
          status_next = ST_DONE;
          state_next  = S_IDLE;
        end else begin
          raddr = idx_p2;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      done     <= 1'b0;
      status_q <= ST_DONE;
    end else begin
      state    <= state_next;
      count    <= count_next;
      done     <= done_next;
      status_q <= status_next;
    end
    if (state == S_IDLE && start) begin
      op_q  <= operation;
      val_q <= value;
    end
    hole <= hole_next;
    idx  <= idx_next;
    // Shadow copy of the first entry, kept current on every write to slot 0.
    if (we && waddr == '0) begin
      smallest <= wdata;
    end
  end

  assign busy           = (state != S_IDLE);
  assign status         = status_q;
  assign entry_count    = count;
  assign smallest_value = (count == '0) ? '0 : smallest;

  `SLI_ASSERT_SAME(a_done_idle, clk, rst, done, !busy, "result strobe while busy")
  `SLI_ASSERT_SAME(a_count_range, clk, rst, 1'b1, count <= CW'(DEPTH), "count above depth")
  `SLI_ASSERT_SAME(a_full_count, clk, rst, done && status_q == ST_FULL,
                   count == CW'(DEPTH), "full status with room left")
  `SLI_ASSERT_NEXT(a_accept_progress, clk, rst, start && !busy, busy || done,
                   "accepted transaction neither busy nor done")
  `SLI_ASSERT_SAME(a_delete_op, clk, rst, state == S_DEL_SHIFT || state == S_DEL_EVAL,
                   op_q == OP_DELETE, "delete walk on an insert")

endmodule
`default_nettype wire

FILE: design/sli_ram.sv
`default_nettype none
module sli_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [sli_pkg::DATA_W-1:0] wdata,
  input  wire logic [AW-1:0]             raddr,
  output logic      [sli_pkg::DATA_W-1:0] rdata
);
  import sli_pkg::*;

  // Simple dual-port storage with a registered read port.
  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sim/tb_sorted_list_insert_delete.sv
`timescale 1ns / 1ps

// Self-checking bench for the sorted list block.
//
// An initial block builds the whole stimulus up front as a queue of pending
// transactions. Each transaction carries its own idle gap. A clocked driver
// presents them on the command port. A second clocked block watches the
// result strobe. At the moment a transaction is accepted, the driver runs it
// through a software copy of the sorted table. The copy is a plain array that
// is kept in ascending signed order. The expected status, count and smallest
// value are queued, and the monitor compares every strobed result against the
// oldest entry in that queue.
module tb_sorted_list_insert_delete;
  import sli_pkg::*;

  localparam int LIST_DEPTH  = 16;
  localparam int CLK_HALF    = 6;
  localparam int RESET_CYCLES = 12;
  // The slowest legal transaction is a full walk of the table, the largest
  // idle gap and the strobe. This limit leaves a wide margin over that.
  localparam int CYCLE_LIMIT = 400000;
  // After the last result, allow at least one full walk of the table before
  // the bench declares the block quiet.
  localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;
  localparam int RANDOM_ITEMS = 800;

  // One pending command, together with the idle cycles that precede it.
  typedef struct {
    logic                     op;
    logic signed [DATA_W-1:0] val;
    int                       gap;
  } list_cmd_t;

  // What the block is expected to report for one command.
  typedef struct {
    status_t                  st;
    logic [4:0]               cnt;
    logic signed [DATA_W-1:0] lowest;
  } list_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic                     operation = OP_INSERT;
  logic signed [DATA_W-1:0] value = '0;
  logic                     busy;
  logic                     done;
  logic [1:0]               status;
  logic [4:0]               entry_count;
  logic signed [DATA_W-1:0] smallest_value;

  list_cmd_t    pending_cmds[$];
  list_result_t expected_results[$];

  // Software copy of the table. Only the first kept_count entries are live.
  logic signed [DATA_W-1:0] kept_vals [LIST_DEPTH];
  int                       kept_count = 0;

  int        idle_cycles = 0;
  int        error_count = 0;
  int        cycle_count = 0;
  list_cmd_t next_cmd;
  list_result_t want;

  sorted_list_insert_delete #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .value         (value),
    .done          (done),
    .status        (status),
    .entry_count   (entry_count),
    .smallest_value(smallest_value)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Apply one command to the software table and return what the block should
  // report. An insert lands in front of any equal entries, and the signed
  // compare matters here. A delete removes the first equal entry.
  function automatic list_result_t apply_list_op(logic op, logic signed [DATA_W-1:0] val);
    list_result_t r;
    int           pos;
    r.st = ST_DONE;
    pos  = 0;
    if (op == OP_INSERT) begin
      if (kept_count >= LIST_DEPTH) begin
        r.st = ST_FULL;
      end else begin
        while (pos < kept_count && kept_vals[pos] < val) pos++;
        for (int i = kept_count; i > pos; i--) kept_vals[i] = kept_vals[i-1];
        kept_vals[pos] = val;
        kept_count++;
      end
    end else begin
      while (pos < kept_count && kept_vals[pos] != val) pos++;
      if (pos >= kept_count) begin
        r.st = ST_NOT_FOUND;
      end else begin
        for (int i = pos; i + 1 < kept_count; i++) kept_vals[i] = kept_vals[i+1];
        kept_count--;
      end
    end
    r.cnt    = kept_count[4:0];
    r.lowest = (kept_count > 0) ? kept_vals[0] : '0;
    return r;
  endfunction

  function automatic void add_cmd(logic op, logic signed [DATA_W-1:0] val, int gap);
    list_cmd_t c;
    c.op  = op;
    c.val = val;
    c.gap = gap;
    pending_cmds.push_back(c);
  endfunction

  // Stimulus. The directed part comes first, followed by random phases.
  initial begin
    logic signed [DATA_W-1:0] pool [6];
    int ins_pct;
    int gappy;
    int total;
    logic op;
    logic signed [DATA_W-1:0] v;

    // Delete on an empty table must report not found, with a smallest value of 0.
    add_cmd(OP_DELETE, 32'sd5, 0);
    // Insert at both ends of the signed range, then zero and minus one.
    add_cmd(OP_INSERT, 32'sh8000_0000, 0);
    add_cmd(OP_INSERT, 32'sh7fff_ffff, 1);
    add_cmd(OP_INSERT, 32'sd0, 0);
    add_cmd(OP_INSERT, -32'sd1, 3);
    // Insert a duplicate, then remove one copy of it.
    add_cmd(OP_INSERT, 32'sd0, 0);
    add_cmd(OP_DELETE, 32'sd0, 0);
    // Delete a value that is not in a non-empty table.
    add_cmd(OP_DELETE, 32'sd123, 2);
    // Fill the table to its last slot. The values are mixed in sign and
    // include some repeats.
    for (int i = 0; i < LIST_DEPTH - 4; i++)
      add_cmd(OP_INSERT, (i % 3 == 0) ? -32'sd1 : $signed(32'(i * 1000 - 5000)), i % 2);
    // Insert into a full table, which must be dropped with status full.
    add_cmd(OP_INSERT, 32'sd42, 0);
    // Remove the extremes again.
    add_cmd(OP_DELETE, 32'sh8000_0000, 0);
    add_cmd(OP_DELETE, 32'sh7fff_ffff, 0);

    // Random phases. Each phase uses a small pool of values so that deletes
    // usually find a match and duplicates are common. A bias toward inserts
    // or deletes drives the table to full or back to empty. Some phases
    // run back to back with no idle cycles at all.
    total = 0;
    while (total < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       ins_pct = 80;
        1:       ins_pct = 25;
        2:       ins_pct = 55;
        default: ins_pct = 45;
      endcase
      gappy = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < 6; k++) begin
        case ($urandom_range(0, 3))
          0:       pool[k] = $signed($urandom());
          1:       pool[k] = $signed(32'($urandom_range(0, 20)) - 32'sd10);
          2:       pool[k] = $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
          default: pool[k] = $signed($urandom());
        endcase
      end
      for (int j = 0; j < 100; j++) begin
        op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_DELETE;
        if ($urandom_range(0, 99) < 85) v = pool[$urandom_range(0, 5)];
        else v = $signed($urandom());
        add_cmd(op, v, gappy ? $urandom_range(0, 9) : 0);
      end
      total += 100;
    end
  end

  // Reset is held for a fixed number of cycles, and released once.
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
  end

  // Driver. Start is held high until the block takes the transaction. The
  // expectation is formed at the edge of acceptance. If the next command
  // has no gap, start stays high and only the payload changes. Otherwise
  // start drops and stays low for the command's idle gap.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        expected_results.push_back(apply_list_op(operation, value));
        idle_cycles <= 0;
        if (pending_cmds.size() > 0 && pending_cmds[0].gap == 0) begin
          next_cmd = pending_cmds.pop_front();
          operation <= next_cmd.op;
          value     <= next_cmd.val;
        end else begin
          start <= 1'b0;
        end
      end else if (!start && pending_cmds.size() > 0) begin
        if (idle_cycles + 1 < pending_cmds[0].gap) begin
          idle_cycles <= idle_cycles + 1;
        end else begin
          next_cmd = pending_cmds.pop_front();
          operation <= next_cmd.op;
          value     <= next_cmd.val;
          start     <= 1'b1;
        end
      end
    end
  end

  // Monitor. Each strobed result must match the oldest expectation, field by field.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d count %0d smallest %0d",
                 $time, status, entry_count, smallest_value);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (status !== want.st) begin
          $display("%0t: status mismatch: expected %0d, got %0d", $time, want.st, status);
          error_count++;
        end
        if (entry_count !== want.cnt) begin
          $display("%0t: entry_count mismatch: expected %0d, got %0d",
                   $time, want.cnt, entry_count);
          error_count++;
        end
        if (smallest_value !== want.lowest) begin
          $display("%0t: smallest_value mismatch: expected %0d, got %0d",
                   $time, want.lowest, smallest_value);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // End of run. Wait until every command has been taken and answered, then
  // give the block time to show any stray result before the verdict.
  initial begin
    @(negedge rst);
    @(posedge clk);
    while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sorted_list_insert_delete.f
+incdir+design
design/sli_pkg.sv
design/sli_ram.sv
design/sorted_list_insert_delete.sv
sim/tb_sorted_list_insert_delete.sv
